// ===== rtl/horner_polynomial_evaluator_unit_defines.svh =====
// Assertion macros shared by the Horner evaluator checker.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define HPE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define HPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hpe_pkg.sv =====
// Shared types and constants of the Horner polynomial evaluator.
package hpe_pkg;

   localparam int DATA_W        = 32;
   localparam int ORDER_W       = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int DEF_MAX_ORDER = 6;
   localparam int DEF_FRAC_BITS = 16;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_POLY_ORDER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BASE  = 3'd1;

   // Item traveling down the cell chain
   typedef struct packed {
      logic signed [DATA_W-1:0] acc;
      logic signed [DATA_W-1:0] x;
      logic                     sat;
      logic                     last;
   } hpe_item_type;

endpackage

// ===== rtl/horner_polynomial_evaluator_unit.sv =====
// Top level of the Horner polynomial evaluator: registers and cell chain.
//
//   channel  direction  payload
//   req_     in         tdata[31:0] sample_in, tlast last_in
//   rsp_     out        tdata[31:0] poly_out, tuser[0] saturated, tlast last_out
//   csr_     in         we, index[2:0], wdata[31:0] (poly_order, coef_0..coef_6)
//
// Flow: one item per cycle while rsp_tready is high; a req transfer reaches
//   rsp_tvalid through the multiply register and the add/saturate register
//   of each of the MAX_ORDER cells. Cells above poly_order pass the
//   accumulator unchanged, so latency does not depend on the order.
// Reset: synchronous, clears all valid bits, poly_order and the coefficients.
// Stalls: each stage holds while its successor is full; bubbles collapse, so
//   the chain keeps taking transfers until every stage holds an item.
module horner_polynomial_evaluator_unit #(
   parameter int MAX_ORDER = hpe_pkg::DEF_MAX_ORDER,
   parameter int FRAC_BITS = hpe_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hpe_pkg::DATA_W-1:0]        req_tdata,   // [31:0] sample_in
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hpe_pkg::DATA_W-1:0]        rsp_tdata,   // [31:0] poly_out
   output logic                              rsp_tuser,   // [0] saturated
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [hpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hpe_pkg::DATA_W-1:0]        csr_wdata
);
   import hpe_pkg::*;

   localparam logic [ORDER_W-1:0] MAX_ORD_C = ORDER_W'(MAX_ORDER);

   // Configuration registers
   logic        [ORDER_W-1:0] order_ff, order_in;
   logic signed [DATA_W-1:0]  coef_ff [MAX_ORDER+1];
   logic signed [DATA_W-1:0]  coef_in [MAX_ORDER+1];
   logic        [ORDER_W-1:0] order_eff;

   // Cell chain links; link 0 is the request side, link MAX_ORDER the result
   logic         chain_valid [MAX_ORDER+1];
   logic         chain_ready [MAX_ORDER+1];
   hpe_item_type chain_item  [MAX_ORDER+1];

   // Register writes; indices past the last coefficient drop the write
   always_comb begin
      order_in = order_ff;
      for (int k = 0; k <= MAX_ORDER; k++) begin
         coef_in[k] = coef_ff[k];
      end
      if (csr_we) begin
         if (csr_index == CSR_POLY_ORDER) begin
            order_in = csr_wdata[ORDER_W-1:0];
         end
         for (int k = 0; k <= MAX_ORDER; k++) begin
            if (csr_index == CSR_COEF_BASE + CSR_IDX_W'(k)) begin
               coef_in[k] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         for (int k = 0; k <= MAX_ORDER; k++) begin
            coef_ff[k] <= '0;
         end
      end else begin
         order_ff <= order_in;
         for (int k = 0; k <= MAX_ORDER; k++) begin
            coef_ff[k] <= coef_in[k];
         end
      end
   end

   // Clamp the step count to the number of cells
   assign order_eff = (order_ff > MAX_ORD_C) ? MAX_ORD_C : order_ff;

   // Seed the accumulator with the leading coefficient
   always_comb begin
      chain_valid[0]     = req_tvalid;
      chain_item[0].acc  = coef_ff[0];
      chain_item[0].x    = req_tdata;
      chain_item[0].sat  = 1'b0;
      chain_item[0].last = req_tlast;
   end
   assign req_tready = chain_ready[0];

   for (genvar j = 1; j <= MAX_ORDER; j++) begin : g_cell
      hpe_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (ORDER_W'(j) <= order_eff),
         .coef      (coef_ff[j]),
         .in_valid  (chain_valid[j-1]),
         .in_ready  (chain_ready[j-1]),
         .in_item   (chain_item[j-1]),
         .out_valid (chain_valid[j]),
         .out_ready (chain_ready[j]),
         .out_item  (chain_item[j])
      );
   end

   // The last cell's add register is the output register
   assign chain_ready[MAX_ORDER] = rsp_tready;
   assign rsp_tvalid = chain_valid[MAX_ORDER];
   assign rsp_tdata  = chain_item[MAX_ORDER].acc;
   assign rsp_tuser  = chain_item[MAX_ORDER].sat;
   assign rsp_tlast  = chain_item[MAX_ORDER].last;

endmodule

// ===== rtl/hpe_cell.sv =====
// One Horner step cell: registered multiply, then round, add and saturate (or pass the accumulator when disabled).
module hpe_cell #(
   parameter int FRAC_BITS = hpe_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic signed [hpe_pkg::DATA_W-1:0]   coef,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  hpe_pkg::hpe_item_type               in_item,
   output logic                                out_valid,
   input  logic                                out_ready,
   output hpe_pkg::hpe_item_type               out_item
);
   import hpe_pkg::*;

   localparam int PW = 2 * DATA_W;
   localparam logic signed [PW-1:0] HALF =
      (FRAC_BITS > 0) ? (64'sd1 <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : 64'sd0;
   localparam logic signed [PW-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PW-1:0] SAT_LO = -64'sh0000_0000_8000_0000;
   localparam logic signed [DATA_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] ACC_MIN = -32'sh8000_0000;

   logic                  a_valid_ff, a_valid_in;
   logic signed [PW-1:0]  a_prod_ff, a_prod_in;
   hpe_item_type          a_item_ff, a_item_in;
   logic                  b_valid_ff, b_valid_in;
   hpe_item_type          b_item_ff, b_item_in;
   logic                  a_ready, b_ready;
   logic signed [PW-1:0]  prod, shifted, sum;

   always_comb begin
      b_ready    = !b_valid_ff || out_ready;
      a_ready    = !a_valid_ff || b_ready;
      prod       = in_item.acc * in_item.x;
      shifted    = (a_prod_ff + HALF) >>> FRAC_BITS;
      sum        = shifted + PW'(coef);

      a_valid_in = a_valid_ff;
      a_prod_in  = a_prod_ff;
      a_item_in  = a_item_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
         a_prod_in  = prod;
         a_item_in  = in_item;
      end

      b_valid_in = b_valid_ff;
      b_item_in  = b_item_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
         b_item_in  = a_item_ff;
         if (enable) begin
            if (sum > SAT_HI) begin
               b_item_in.acc = ACC_MAX;
               b_item_in.sat = 1'b1;
            end else if (sum < SAT_LO) begin
               b_item_in.acc = ACC_MIN;
               b_item_in.sat = 1'b1;
            end else begin
               b_item_in.acc = sum[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_prod_ff <= a_prod_in;
      a_item_ff <= a_item_in;
      b_item_ff <= b_item_in;
   end

   assign in_ready  = a_ready;
   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ===== rtl/hpe_checker.sv =====
// Port-level checker for the Horner evaluator, bound to the top level.
`include "horner_polynomial_evaluator_unit_defines.svh"

module hpe_checker #(
   parameter int MAX_ORDER = hpe_pkg::DEF_MAX_ORDER
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [hpe_pkg::DATA_W-1:0] rsp_tdata,
   input logic                       rsp_tuser,
   input logic                       rsp_tlast
);
   import hpe_pkg::*;

   localparam int CAP   = 2 * MAX_ORDER;
   localparam int CNT_W = $clog2(CAP + 2);

   logic [CNT_W-1:0] count_ff, count_in;

   // Track items in flight
   always_comb begin
      count_in = count_ff + CNT_W'(req_tvalid && req_tready)
                          - CNT_W'(rsp_tvalid && rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `HPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "result changed while stalled")
   `HPE_ASSERT_IMPL(a_stall_source, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready, "request side stalled without a stalled result")
   `HPE_ASSERT_IMPL(a_no_phantom, clock, reset, rsp_tvalid,
      count_ff != '0, "result offered with no item in flight")
   `HPE_ASSERT_IMPL(a_capacity, clock, reset, 1'b1,
      count_ff <= CNT_W'(CAP), "more items in flight than the chain holds")

endmodule

bind horner_polynomial_evaluator_unit hpe_checker #(.MAX_ORDER(MAX_ORDER)) u_hpe_checker (.*);
